// ----- rtl/core/ibrr_pkg.sv -----
// Shared types and constants for the IPv4 binary range route lookup block.
// No dependencies; every other file of the block uses it by scoped names.
`timescale 1ns / 1ps

package ibrr_pkg;

   localparam int ADDR_W  = 32;   // IPv4 address width
   localparam int LEN_W   = 6;    // prefix length field width
   localparam int SLOT_W  = 10;   // entry_index and match_index width
   localparam int COUNT_W = 11;   // entry_count register width

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(ADDR_W);

   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   // Outcome of one probe of the compare unit.
   typedef struct packed {
      logic contains;   // lower < address <= upper
      logic go_left;    // address <= lower
   } probe_result_type;

endpackage

// ----- rtl/core/ibrr_if.sv -----
// Handshake channels of the route lookup block: request, response and register write.
// Depends on ibrr_pkg for the field widths.
`timescale 1ns / 1ps

interface ibrr_req_if;
   logic                        valid;
   logic                        ready;
   logic                        operation;
   logic [ibrr_pkg::SLOT_W-1:0] entry_index;
   logic [ibrr_pkg::ADDR_W-1:0] prefix_address;
   logic [ibrr_pkg::LEN_W-1:0]  prefix_length;
   logic [ibrr_pkg::ADDR_W-1:0] lookup_address;

   modport source (output valid, operation, entry_index, prefix_address,
                   prefix_length, lookup_address, input ready);
   modport sink   (input valid, operation, entry_index, prefix_address,
                   prefix_length, lookup_address, output ready);
endinterface

interface ibrr_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        found;
   logic [ibrr_pkg::SLOT_W-1:0] match_index;

   modport source (output valid, found, match_index, input ready);
   modport sink   (input valid, found, match_index, output ready);
endinterface

interface ibrr_csr_if;
   logic                         valid;
   logic                         ready;
   logic [ibrr_pkg::COUNT_W-1:0] entry_count;

   modport source (output valid, entry_count, input ready);
   modport sink   (input valid, entry_count, output ready);
endinterface

// ----- rtl/core/ibrr_range.sv -----
// Converts a prefix and a length into the stored range (lower, upper].
// Depends on ibrr_pkg.
`timescale 1ns / 1ps

module ibrr_range (
   input  logic [ibrr_pkg::ADDR_W-1:0] prefix_address,
   input  logic [ibrr_pkg::LEN_W-1:0]  prefix_length,
   output logic [ibrr_pkg::ADDR_W-1:0] lower,
   output logic [ibrr_pkg::ADDR_W-1:0] upper
);

   logic [ibrr_pkg::LEN_W-1:0]  len_clamped;
   logic [ibrr_pkg::ADDR_W-1:0] mask;
   logic [ibrr_pkg::ADDR_W-1:0] base;

   always_comb begin
      len_clamped = (prefix_length > ibrr_pkg::MAX_LEN) ? ibrr_pkg::MAX_LEN : prefix_length;
      // A shift by the full width yields zero, so length 32 gives an all-ones mask.
      mask  = ~({ibrr_pkg::ADDR_W{1'b1}} >> len_clamped);
      base  = prefix_address & mask;
      lower = (base == '0) ? '0 : base - ibrr_pkg::ADDR_W'(1);
      upper = base | ~mask;
   end

endmodule

// ----- rtl/core/ibrr_table.sv -----
// Range table: lower and upper bound memories, one write and one registered read port.
// Depends on ibrr_pkg.
`timescale 1ns / 1ps

module ibrr_table #(
   parameter int TABLE_DEPTH = 1024,
   parameter int IDX_W       = 10
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [IDX_W-1:0]            wr_addr,
   input  logic [ibrr_pkg::ADDR_W-1:0] wr_lower,
   input  logic [ibrr_pkg::ADDR_W-1:0] wr_upper,
   input  logic [IDX_W-1:0]            rd_addr,
   output logic [ibrr_pkg::ADDR_W-1:0] rd_lower,
   output logic [ibrr_pkg::ADDR_W-1:0] rd_upper
);

   logic [ibrr_pkg::ADDR_W-1:0] lower_mem [TABLE_DEPTH];
   logic [ibrr_pkg::ADDR_W-1:0] upper_mem [TABLE_DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         lower_mem[wr_addr] <= wr_lower;
         upper_mem[wr_addr] <= wr_upper;
      end
      rd_lower <= lower_mem[rd_addr];
      rd_upper <= upper_mem[rd_addr];
   end

endmodule

// ----- rtl/core/ibrr_cmp.sv -----
// Shared compare unit: tests one probed range against the search address.
// Depends on ibrr_pkg.
`timescale 1ns / 1ps

module ibrr_cmp (
   input  logic [ibrr_pkg::ADDR_W-1:0] address,
   input  logic [ibrr_pkg::ADDR_W-1:0] lower,
   input  logic [ibrr_pkg::ADDR_W-1:0] upper,
   output ibrr_pkg::probe_result_type  result
);

   always_comb begin
      result.go_left  = (address <= lower);
      result.contains = !result.go_left && (address <= upper);
   end

endmodule

// ----- rtl/core/ipv4_binary_range_route_lookup.sv -----
// Top level of the IPv4 binary range route lookup: sequencer, search registers, result stage.
// Depends on ibrr_pkg, ibrr_if, ibrr_range, ibrr_table and ibrr_cmp.
//
//   Channel  | Direction | Handshake    | Carries
//   ---------+-----------+--------------+------------------------------------------------
//   req_chan | in        | valid/ready  | operation, entry_index, prefix, length, address
//   rsp_chan | out       | valid/ready  | found, match_index
//   csr_chan | in        | valid/ready  | entry_count (always ready)
//
// A write item goes from ST_IDLE straight to ST_FINISH; a lookup runs ST_PROBE and
// ST_COMPARE for each probe, at most floor(log2(entry_count)) + 1 (11 for 1024 entries).
// Each probe costs one registered read of the bound memories plus one pass of the compare.
// Reset is synchronous and clears the sequencer, the result valid and entry_count;
// the bound memories are not cleared. The block takes one item at a time: req_chan is
// ready only while the sequencer is idle, and it may accept the next item while the
// previous result still waits on rsp_chan. A stalled result holds its value.
`timescale 1ns / 1ps

module ipv4_binary_range_route_lookup #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   ibrr_req_if.sink    req_chan,
   ibrr_rsp_if.source  rsp_chan,
   ibrr_csr_if.sink    csr_chan
);

   // Memory index width, search bound width (must hold TABLE_DEPTH itself) and a width
   // wide enough to compare every field against TABLE_DEPTH.
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW    = $clog2(TABLE_DEPTH + 1);
   localparam int XW0   = (CW > ibrr_pkg::COUNT_W) ? CW : ibrr_pkg::COUNT_W;
   localparam int XW    = (XW0 > IDX_W) ? XW0 : IDX_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_COMPARE,
      ST_FINISH
   } state_type;

   state_type                    state_ff, state_in;
   logic [ibrr_pkg::COUNT_W-1:0] entry_count_ff, entry_count_in;
   logic [ibrr_pkg::ADDR_W-1:0]  address_ff, address_in;
   logic [CW-1:0]                left_ff, left_in;     // first slot still in range
   logic [CW-1:0]                end_ff, end_in;       // one past the last slot in range
   logic [CW-1:0]                mid_ff, mid_in;       // slot being probed
   logic [CW-1:0]                hit_ff, hit_in;       // last matching slot
   logic                         found_ff, found_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         rsp_found_ff, rsp_found_in;
   logic [ibrr_pkg::SLOT_W-1:0]  rsp_index_ff, rsp_index_in;

   logic                         req_accept;
   logic                         table_wr_en;
   logic [XW-1:0]                slot_ext;
   logic [XW-1:0]                count_ext;
   logic [XW-1:0]                hit_ext;
   logic [CW-1:0]                count_clamped;
   logic [CW:0]                  mid_sum;
   logic [CW-1:0]                mid_next;
   logic [ibrr_pkg::ADDR_W-1:0]  range_lower, range_upper;
   logic [ibrr_pkg::ADDR_W-1:0]  probe_lower, probe_upper;
   ibrr_pkg::probe_result_type   probe;

   assign req_chan.ready   = (state_ff == ST_IDLE);
   assign csr_chan.ready   = 1'b1;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.found   = rsp_found_ff;
   assign rsp_chan.match_index = rsp_index_ff;

   assign req_accept = req_chan.valid && req_chan.ready;

   // Writes beyond the table are dropped; the item still returns a not-found result.
   assign slot_ext    = XW'(req_chan.entry_index);
   assign table_wr_en = req_accept && (req_chan.operation == ibrr_pkg::OP_WRITE)
                        && (slot_ext < XW'(TABLE_DEPTH));

   // A programmed count above the table depth searches the whole table.
   assign count_ext     = XW'(entry_count_ff);
   assign count_clamped = (count_ext > XW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                         : count_ext[CW-1:0];

   // Midpoint of the inclusive range [left, end - 1], rounded down.
   assign mid_sum  = {1'b0, left_ff} + {1'b0, end_ff} - (CW + 1)'(1);
   assign mid_next = mid_sum[CW:1];

   assign hit_ext = XW'(hit_ff);

   ibrr_range u_range (
      .prefix_address (req_chan.prefix_address),
      .prefix_length  (req_chan.prefix_length),
      .lower          (range_lower),
      .upper          (range_upper)
   );

   ibrr_table #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .IDX_W       (IDX_W)
   ) u_table (
      .clock    (clock),
      .wr_en    (table_wr_en),
      .wr_addr  (slot_ext[IDX_W-1:0]),
      .wr_lower (range_lower),
      .wr_upper (range_upper),
      .rd_addr  (mid_next[IDX_W-1:0]),
      .rd_lower (probe_lower),
      .rd_upper (probe_upper)
   );

   ibrr_cmp u_cmp (
      .address (address_ff),
      .lower   (probe_lower),
      .upper   (probe_upper),
      .result  (probe)
   );

   always_comb begin
      state_in       = state_ff;
      entry_count_in = entry_count_ff;
      address_in     = address_ff;
      left_in        = left_ff;
      end_in         = end_ff;
      mid_in         = mid_ff;
      hit_in         = hit_ff;
      found_in       = found_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_found_in   = rsp_found_ff;
      rsp_index_in   = rsp_index_ff;

      if (csr_chan.valid) begin
         entry_count_in = csr_chan.entry_count;
      end

      // The waiting result leaves as soon as the sink takes it.
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               found_in   = 1'b0;
               hit_in     = '0;
               address_in = req_chan.lookup_address;
               left_in    = '0;
               end_in     = count_clamped;
               // A write has already gone to the table this cycle.
               state_in   = (req_chan.operation == ibrr_pkg::OP_LOOKUP) ? ST_PROBE
                                                                        : ST_FINISH;
            end
         end
         ST_PROBE: begin
            // The read of the midpoint slot is issued here and lands in the next cycle.
            if (left_ff < end_ff) begin
               mid_in   = mid_next;
               state_in = ST_COMPARE;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_COMPARE: begin
            if (probe.contains) begin
               found_in = 1'b1;
               hit_in   = mid_ff;
               left_in  = mid_ff + CW'(1);
            end else if (probe.go_left) begin
               end_in   = mid_ff;
            end else begin
               left_in  = mid_ff + CW'(1);
            end
            state_in = ST_PROBE;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_index_in = found_ff ? hit_ext[ibrr_pkg::SLOT_W-1:0] : '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         entry_count_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         entry_count_ff <= entry_count_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      address_ff   <= address_in;
      left_ff      <= left_in;
      end_ff       <= end_in;
      mid_ff       <= mid_in;
      hit_ff       <= hit_in;
      found_ff     <= found_in;
      rsp_found_ff <= rsp_found_in;
      rsp_index_ff <= rsp_index_in;
   end

endmodule

// ----- rtl/core/ibrr_checker.sv -----
// Port-level checker for the route lookup block, bound to the top level.
// Depends on ibrr_pkg and ipv4_binary_range_route_lookup.
`timescale 1ns / 1ps

module ibrr_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        found,
   input logic [ibrr_pkg::SLOT_W-1:0] match_index
);

   // A stalled result keeps its value until it is taken.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(found) && $stable(match_index))
      else $error("stalled result changed or dropped");

   // Once an item is taken the block is busy with it for at least the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("block ready right after accepting an item");

   // A result that did not match always reports slot zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !found |-> match_index == '0)
      else $error("not-found result carries a nonzero index");

   // Reset leaves no result pending.
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind ipv4_binary_range_route_lookup ibrr_checker u_ibrr_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .found       (rsp_chan.found),
   .match_index (rsp_chan.match_index)
);

// ----- dv/ipv4_binary_range_route_lookup_test.sv -----
// Self-checking testbench for the IPv4 binary range route lookup block.
// Depends on ibrr_pkg, the ibrr_if channel interfaces and the block's RTL.
`timescale 1ns / 1ps

module ipv4_binary_range_route_lookup_test;

   localparam int TABLE_DEPTH   = 1024;
   localparam int RANDOM_ITEMS  = 780;
   localparam int STALL_LIMIT   = 2000;
   localparam int SETTLE_CYCLES = 40;

   typedef struct {
      logic                        op;
      logic [ibrr_pkg::SLOT_W-1:0] slot;
      logic [ibrr_pkg::ADDR_W-1:0] prefix;
      logic [ibrr_pkg::LEN_W-1:0]  plen;
      logic [ibrr_pkg::ADDR_W-1:0] addr;
      bit                          drain_first;   // hold this item until all results are back
   } route_req_type;

   typedef struct packed {
      logic                        found;
      logic [ibrr_pkg::SLOT_W-1:0] match_index;
   } route_rsp_type;

   logic clock = 1'b0;
   logic reset;

   ibrr_req_if req_bus ();
   ibrr_rsp_if rsp_bus ();
   ibrr_csr_if csr_bus ();

   ipv4_binary_range_route_lookup #(.TABLE_DEPTH(TABLE_DEPTH)) u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_chan(req_bus),
      .rsp_chan(rsp_bus),
      .csr_chan(csr_bus)
   );

   always #5 clock = ~clock;

   // Predicted view of the route table and the entry_count register.
   logic [ibrr_pkg::ADDR_W-1:0]  route_lower [TABLE_DEPTH];
   logic [ibrr_pkg::ADDR_W-1:0]  route_upper [TABLE_DEPTH];
   logic [ibrr_pkg::COUNT_W-1:0] route_count = '0;

   // Table contents planned by the stimulus, used to aim lookups at real ranges.
   logic [ibrr_pkg::ADDR_W-1:0] plan_prefix [TABLE_DEPTH];
   logic [ibrr_pkg::LEN_W-1:0]  plan_length [TABLE_DEPTH];
   logic [ibrr_pkg::ADDR_W-1:0] plan_lower  [TABLE_DEPTH];
   logic [ibrr_pkg::ADDR_W-1:0] plan_upper  [TABLE_DEPTH];
   int                          plan_size = 0;

   // Slots 0 .. written_prefix-1 have all been written, so any entry_count up to
   // this value only probes written slots.
   int written_prefix = 0;

   route_req_type pending_requests [$];
   route_rsp_type expected_routes [$];
   route_req_type staged_request;

   int queued_items    = 0;
   int results_checked = 0;
   int mismatch_count  = 0;
   int send_gap        = 0;
   int recv_gap        = 0;
   int stall_cycles    = 0;
   bit sender_eager    = 1'b0;
   bit receiver_eager  = 1'b0;

   function automatic logic [ibrr_pkg::ADDR_W-1:0] prefix_mask(
      input logic [ibrr_pkg::LEN_W-1:0] plen);
      int bits;
      bits = (plen > ibrr_pkg::MAX_LEN) ? ibrr_pkg::ADDR_W : int'(plen);
      return (bits == 0) ? '0 : (32'hFFFF_FFFF << (ibrr_pkg::ADDR_W - bits));
   endfunction

   // A zero base keeps the lower bound at zero, so address zero never hits it.
   function automatic logic [ibrr_pkg::ADDR_W-1:0] range_lower(
      input logic [ibrr_pkg::ADDR_W-1:0] pfx, input logic [ibrr_pkg::LEN_W-1:0] plen);
      logic [ibrr_pkg::ADDR_W-1:0] base;
      base = pfx & prefix_mask(plen);
      return (base == '0) ? '0 : base - 1;
   endfunction

   function automatic logic [ibrr_pkg::ADDR_W-1:0] range_upper(
      input logic [ibrr_pkg::ADDR_W-1:0] pfx, input logic [ibrr_pkg::LEN_W-1:0] plen);
      return pfx | ~prefix_mask(plen);
   endfunction

   // Binary search that remembers the last probe whose range holds the address.
   function automatic route_rsp_type search_route_table(
      input logic [ibrr_pkg::ADDR_W-1:0] addr);
      route_rsp_type res;
      int left, right, mid;
      res   = '0;
      left  = 0;
      right = ((int'(route_count) > TABLE_DEPTH) ? TABLE_DEPTH : int'(route_count)) - 1;
      while (left <= right) begin
         mid = (left + right) / 2;
         if (route_lower[mid] < addr && addr <= route_upper[mid]) begin
            res.found       = 1'b1;
            res.match_index = ibrr_pkg::SLOT_W'(mid);
            left            = mid + 1;
         end else if (addr <= route_lower[mid]) begin
            right = mid - 1;
         end else begin
            left = mid + 1;
         end
      end
      return res;
   endfunction

   function automatic void predict_route_request(input route_req_type r);
      route_rsp_type res;
      res = '0;
      if (r.op == ibrr_pkg::OP_WRITE) begin
         route_lower[r.slot] = range_lower(r.prefix, r.plen);
         route_upper[r.slot] = range_upper(r.prefix, r.plen);
      end else begin
         res = search_route_table(r.addr);
      end
      expected_routes.push_back(res);
   endfunction

   task automatic report_mismatch(input string msg);
      mismatch_count++;
      $display("MISMATCH at %0t: %s", $realtime, msg);
   endtask

   function automatic void queue_write(input int slot,
                                       input logic [ibrr_pkg::ADDR_W-1:0] pfx,
                                       input int plen);
      route_req_type r;
      r.op          = ibrr_pkg::OP_WRITE;
      r.slot        = ibrr_pkg::SLOT_W'(slot);
      r.prefix      = pfx;
      r.plen        = ibrr_pkg::LEN_W'(plen);
      r.addr        = $urandom;
      r.drain_first = 1'b0;
      pending_requests.push_back(r);
      queued_items++;
   endfunction

   // Fields a lookup does not use carry random values on purpose.
   function automatic void queue_lookup(input logic [ibrr_pkg::ADDR_W-1:0] addr,
                                        input bit drain_first);
      route_req_type r;
      r.op          = ibrr_pkg::OP_LOOKUP;
      r.slot        = ibrr_pkg::SLOT_W'($urandom);
      r.prefix      = $urandom;
      r.plen        = ibrr_pkg::LEN_W'($urandom);
      r.addr        = addr;
      r.drain_first = drain_first;
      pending_requests.push_back(r);
      queued_items++;
   endfunction

   // Mostly ordinary lengths, sometimes /0, /32 or an oversized length.
   function automatic int random_length();
      case ($urandom_range(0, 19))
         0:       return 0;
         1:       return $urandom_range(33, 63);
         2:       return ibrr_pkg::ADDR_W;
         default: return $urandom_range(4, 28);
      endcase
   endfunction

   // Builds n prefixes, some nested inside the previous one, optionally sorts them
   // by lower bound, and queues the writes to slots 0 .. n-1.
   task automatic plan_route_table(input int n, input bit keep_sorted);
      logic [ibrr_pkg::ADDR_W-1:0] key_prefix, key_lower, key_upper;
      logic [ibrr_pkg::LEN_W-1:0]  key_length;
      int j;
      for (int i = 0; i < n; i++) begin
         if (i > 0 && $urandom_range(0, 2) == 0 && plan_length[i-1] < ibrr_pkg::MAX_LEN)
         begin
            plan_length[i] = ibrr_pkg::LEN_W'($urandom_range(int'(plan_length[i-1]) + 1,
                                                             ibrr_pkg::ADDR_W));
            plan_prefix[i] = plan_prefix[i-1] ^ ($urandom & ~prefix_mask(plan_length[i-1]));
         end else begin
            plan_length[i] = ibrr_pkg::LEN_W'(random_length());
            plan_prefix[i] = $urandom;
         end
         plan_lower[i] = range_lower(plan_prefix[i], plan_length[i]);
         plan_upper[i] = range_upper(plan_prefix[i], plan_length[i]);
      end
      if (keep_sorted) begin
         for (int i = 1; i < n; i++) begin
            key_prefix = plan_prefix[i];
            key_length = plan_length[i];
            key_lower  = plan_lower[i];
            key_upper  = plan_upper[i];
            j = i - 1;
            while (j >= 0 && plan_lower[j] > key_lower) begin
               plan_prefix[j+1] = plan_prefix[j];
               plan_length[j+1] = plan_length[j];
               plan_lower[j+1]  = plan_lower[j];
               plan_upper[j+1]  = plan_upper[j];
               j--;
            end
            plan_prefix[j+1] = key_prefix;
            plan_length[j+1] = key_length;
            plan_lower[j+1]  = key_lower;
            plan_upper[j+1]  = key_upper;
         end
      end
      for (int i = 0; i < n; i++)
         queue_write(i, plan_prefix[i], int'(plan_length[i]));
      plan_size = n;
      if (n > written_prefix)
         written_prefix = n;
   endtask

   // Aims at range edges and interiors of the planned table, or anywhere at all.
   function automatic logic [ibrr_pkg::ADDR_W-1:0] pick_lookup_address();
      logic [ibrr_pkg::ADDR_W-1:0] lo, hi, span;
      int k;
      if (plan_size == 0 || $urandom_range(0, 5) == 0)
         return $urandom;
      k    = $urandom_range(0, plan_size - 1);
      lo   = plan_lower[k];
      hi   = plan_upper[k];
      span = hi - lo;
      case ($urandom_range(0, 4))
         0:       return lo;
         1:       return lo + 1;
         2:       return hi;
         3:       return hi + 1;
         default: return (span == '0) ? hi : lo + 1 + ($urandom % span);
      endcase
   endfunction

   task automatic wait_for_results();
      while (results_checked != queued_items)
         @(posedge clock);
   endtask

   // The register is only written once the block has returned every result.
   task automatic write_entry_count(input int value);
      wait_for_results();
      @(posedge clock);
      csr_bus.valid       <= 1'b1;
      csr_bus.entry_count <= ibrr_pkg::COUNT_W'(value);
      do @(posedge clock); while (!csr_bus.ready);
      route_count = ibrr_pkg::COUNT_W'(value);
      csr_bus.valid <= 1'b0;
   endtask

   // Request driver: predicts each accepted item, then waits its random gap.
   always @(posedge clock) begin : request_driver
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            predict_route_request(staged_request);
            send_gap = sender_eager ? 0 : $urandom_range(0, 4);
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (pending_requests.size() != 0 &&
                         !(pending_requests[0].drain_first &&
                           expected_routes.size() != 0)) begin
               staged_request = pending_requests.pop_front();
               req_bus.valid          <= 1'b1;
               req_bus.operation      <= staged_request.op;
               req_bus.entry_index    <= staged_request.slot;
               req_bus.prefix_address <= staged_request.prefix;
               req_bus.prefix_length  <= staged_request.plen;
               req_bus.lookup_address <= staged_request.addr;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: compares each accepted result with the oldest prediction.
   always @(posedge clock) begin : result_monitor
      route_rsp_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_routes.size() == 0) begin
               report_mismatch($sformatf("result with nothing pending: found=%0b index=%0d",
                                         rsp_bus.found, rsp_bus.match_index));
            end else begin
               want = expected_routes.pop_front();
               results_checked++;
               if (rsp_bus.found !== want.found)
                  report_mismatch($sformatf("result %0d: found=%0b, predicted %0b",
                                            results_checked, rsp_bus.found, want.found));
               if (rsp_bus.match_index !== want.match_index)
                  report_mismatch($sformatf("result %0d: match_index=%0d, predicted %0d",
                                            results_checked, rsp_bus.match_index,
                                            want.match_index));
            end
            recv_gap = receiver_eager ? 0 : $urandom_range(0, 4);
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          (csr_bus.valid && csr_bus.ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles == STALL_LIMIT) begin
         $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
         $display("ipv4_binary_range_route_lookup test failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin : stimulus
      int n, shape, random_start;
      int lo_slot, hi_slot, mid_slot;
      reset                  = 1'b1;
      req_bus.valid          = 1'b0;
      req_bus.operation      = ibrr_pkg::OP_WRITE;
      req_bus.entry_index    = '0;
      req_bus.prefix_address = '0;
      req_bus.prefix_length  = '0;
      req_bus.lookup_address = '0;
      rsp_bus.ready          = 1'b0;
      csr_bus.valid          = 1'b0;
      csr_bus.entry_count    = '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // With entry_count at its reset value no slot is probed.
      queue_lookup(32'h0000_0000, 1'b0);
      queue_lookup(32'hFFFF_FFFF, 1'b0);

      // A small sorted table: default route with a zero base, nested prefixes with
      // host bits set in the address, and lengths above 32 on the last entries.
      queue_write(0, 32'h0000_0000, 0);
      queue_write(1, 32'h0AFF_FFFF, 8);
      queue_write(2, 32'h0A01_FFFF, 16);
      queue_write(3, 32'h0A01_0203, 32);
      queue_write(4, 32'hC0A8_0101, 63);
      queue_write(5, 32'hFFFF_FFFF, 33);
      queue_write(TABLE_DEPTH - 1, 32'hFFFF_FFFF, 63);
      written_prefix = 6;
      write_entry_count(6);
      plan_size = 0;
      queue_lookup(32'h0000_0000, 1'b0);
      queue_lookup(32'h0A01_0203, 1'b0);
      queue_lookup(32'h0A01_05FF, 1'b0);
      queue_lookup(32'h0AFF_FFFF, 1'b1);
      queue_lookup(32'hC0A8_0101, 1'b0);
      queue_lookup(32'hC0A8_0100, 1'b0);
      queue_lookup(32'hFFFF_FFFF, 1'b0);
      queue_lookup(32'h7FFF_FFFF, 1'b0);
      queue_lookup(32'h09FF_FFFF, 1'b0);
      write_entry_count(1);
      queue_lookup(32'h1234_5678, 1'b0);

      // Full-table searches. Address zero always moves left and the all-ones
      // address always moves right, so only the slots on those two paths are
      // written. Counts at and above the table depth must search the same slots.
      lo_slot = 0;
      hi_slot = TABLE_DEPTH - 1;
      while (lo_slot <= hi_slot) begin
         mid_slot = (lo_slot + hi_slot) / 2;
         queue_write(mid_slot, $urandom, random_length());
         hi_slot = mid_slot - 1;
      end
      lo_slot = 0;
      hi_slot = TABLE_DEPTH - 1;
      while (lo_slot <= hi_slot) begin
         mid_slot = (lo_slot + hi_slot) / 2;
         queue_write(mid_slot, $urandom, random_length());
         lo_slot = mid_slot + 1;
      end
      queue_write((TABLE_DEPTH - 1) / 2, 32'h0000_0000, 0);
      queue_write(TABLE_DEPTH - 1, 32'hFFFF_FFFF, 32);
      write_entry_count(TABLE_DEPTH);
      queue_lookup(32'h0000_0000, 1'b0);
      queue_lookup(32'hFFFF_FFFF, 1'b0);
      write_entry_count(2047);
      queue_lookup(32'h0000_0000, 1'b0);
      queue_lookup(32'hFFFF_FFFF, 1'b0);
      write_entry_count(TABLE_DEPTH + 1);
      queue_lookup(32'h0000_0000, 1'b0);
      queue_lookup(32'hFFFF_FFFF, 1'b0);
      // The last slot no longer holds the all-ones address; an earlier probe wins.
      queue_write(TABLE_DEPTH - 1, 32'h0A00_0000, 8);
      queue_lookup(32'hFFFF_FFFF, 1'b0);

      // Random phases: rewrite the head of the table, mostly sorted and small,
      // set entry_count, then run lookups with a little write noise.
      random_start = queued_items;
      while (queued_items - random_start < RANDOM_ITEMS) begin
         shape = $urandom_range(0, 19);
         if (shape == 0)
            n = 0;
         else if (shape < 15)
            n = $urandom_range(1, 16);
         else if (shape < 19)
            n = $urandom_range(17, 96);
         else
            n = $urandom_range(97, 200);
         sender_eager   = ($urandom_range(0, 3) == 0);
         receiver_eager = ($urandom_range(0, 3) == 0);
         plan_route_table(n, $urandom_range(0, 7) != 0);
         write_entry_count(($urandom_range(0, 9) == 0) ? $urandom_range(0, written_prefix)
                                                       : n);
         repeat ($urandom_range(8, 40)) begin
            if ($urandom_range(0, 7) == 0)
               queue_write($urandom_range(0, TABLE_DEPTH - 1), $urandom, random_length());
            else
               queue_lookup(pick_lookup_address(), $urandom_range(0, 49) == 0);
         end
      end

      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("ipv4_binary_range_route_lookup test passed");
      else
         $display("ipv4_binary_range_route_lookup test failed");
      $finish;
   end

endmodule
